/* design/assert_macros.svh */
// Assertion macros used by the load monitor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/lma_pkg.sv */
// Package with shared constants and types of the load monitor.
package lma_pkg;
  localparam int TimeW  = 48;
  localparam int WordW  = 32;
  localparam int PctW   = 14;
  localparam int CoolW  = 40;
  localparam int ThrW   = 7;
  localparam int DivNW  = 48;
  localparam int DivDW  = 48;
  localparam logic [PctW-1:0] FullScale = 14'd10000;
  localparam logic [PctW-1:0] CpuMargin = 14'd500;
  localparam logic [PctW-1:0] MemMargin = 14'd1000;
  localparam logic [2:0] CfgIntTotal = 3'd0;
  localparam logic [2:0] CfgExtTotal = 3'd1;
  localparam logic [2:0] CfgCpuPct   = 3'd2;
  localparam logic [2:0] CfgMemPct   = 3'd3;
  localparam logic [2:0] CfgCooldown = 3'd4;
  localparam logic [1:0] AlertNone = 2'd0;
  localparam logic [1:0] AlertWarn = 2'd1;
  localparam logic [1:0] AlertCrit = 2'd2;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

/* design/load_monitor_alerts.sv */
// Load monitor top level: sequencer, state, alert logic and output register.
// Usage: a sample beat on in_* is taken when in_valid is high and in_stall low.
// The block computes both core loads and both heap shares with one shared
// bit-serial divider. Each division has a start step, one step per quotient
// bit and a done step; the four divisions run in turn, and out_valid rises
// after the alert step that follows the last one.
// Only one item is in flight; in_stall stays high while it is worked on and
// while its result waits in the output register.
// The result beat is held on out_* with out_valid high until out_stall is low.
// A stalled result is held unchanged and the next item waits.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, and registers must be written only while the block is idle.
// Reset (rst_n low, synchronous) restores register defaults (totals 0, cpu
// threshold 90, memory threshold 85, cooldown 10000000 us), clears prior
// time, idle counters and alert times, and sets the heap minimums to all ones.
// The next sample waits for the four divisions, done in turn on the single
// divider, and for the result to be taken; out_stall holding the result
// delays the next sample further.
module load_monitor_alerts (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_sample_time,
  input  logic [31:0] in_idle_count_a,
  input  logic [31:0] in_idle_count_b,
  input  logic        in_idle_a_present,
  input  logic        in_idle_b_present,
  input  logic [31:0] in_free_internal,
  input  logic [31:0] in_free_external,
  input  logic [31:0] in_low_water_internal,
  input  logic [31:0] in_low_water_external,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_busy_a,
  output logic [13:0] out_busy_b,
  output logic [13:0] out_busy_total,
  output logic [31:0] out_history_min_internal,
  output logic [31:0] out_history_min_external,
  output logic [13:0] out_used_internal,
  output logic [13:0] out_used_external,
  output logic [1:0]  out_cpu_alert,
  output logic [1:0]  out_internal_alert,
  output logic [1:0]  out_external_alert,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_data
);
  import lma_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_A, S_WAIT_A, S_DIV_B, S_WAIT_B, S_DIV_I, S_WAIT_I,
    S_DIV_E, S_WAIT_E, S_ALERT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [WordW-1:0] int_total_r, ext_total_r;
  logic [ThrW-1:0]  cpu_pct_r, mem_pct_r;
  logic [CoolW-1:0] cooldown_r;

  logic [TimeW-1:0] prev_time_r;
  logic [WordW-1:0] prev_idle_a_r, prev_idle_b_r;
  logic [WordW-1:0] min_int_r, min_ext_r;
  logic [TimeW-1:0] last_cpu_r, last_int_r, last_ext_r;

  // Latched sample.
  logic [TimeW-1:0] now_r;
  logic [TimeW-1:0] dt_r;
  logic             calc_r;
  logic [WordW-1:0] ia_r, ib_r, fi_r, fe_r;

  logic [PctW-1:0] ba_r, bb_r, ui_r, ue_r;

  logic [PctW-1:0] bt_r;
  logic [1:0] a_cpu_r, a_int_r, a_ext_r;

  logic             div_start;
  logic [DivNW-1:0] div_num;
  logic [DivDW-1:0] div_den;
  div_ctl_t         div_ctl;
  logic [DivNW-1:0] div_q;

  lma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .ctl(div_ctl), .quot(div_q)
  );

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Numerator helpers; delta * 10000 fits in 46 bits.
  logic [WordW-1:0] da, db, ui_diff, ue_diff;
  assign da = ia_r - prev_idle_a_r;
  assign db = ib_r - prev_idle_b_r;
  assign ui_diff = int_total_r - fi_r;
  assign ue_diff = ext_total_r - fe_r;

  function automatic logic [DivNW-1:0] scale(input logic [WordW-1:0] v);
    scale = DivNW'(v) * DivNW'(FullScale);
  endfunction

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      S_DIV_A: begin
        div_start = 1'b1; div_num = scale(da); div_den = dt_r;
      end
      S_DIV_B: begin
        div_start = 1'b1; div_num = scale(db); div_den = dt_r;
      end
      S_DIV_I: begin
        div_start = 1'b1; div_num = scale(ui_diff); div_den = DivDW'(int_total_r);
      end
      S_DIV_E: begin
        div_start = 1'b1; div_num = scale(ue_diff); div_den = DivDW'(ext_total_r);
      end
      default: ;
    endcase
  end

  // Busy from idle quotient, clamped.
  logic [PctW-1:0] busy_q;
  assign busy_q = (div_q > DivNW'(FullScale)) ? '0 : (FullScale - PctW'(div_q));

  // Alert evaluation.
  logic [PctW-1:0] cpu_thr, mem_thr;
  assign cpu_thr = PctW'(cpu_pct_r) * 14'd100;
  assign mem_thr = PctW'(mem_pct_r) * 14'd100;

  function automatic logic cool_ok(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] last,
                                   input logic [CoolW-1:0] cd);
    cool_ok = (now >= last) && ((now - last) >= TimeW'(cd));
  endfunction

  logic [PctW:0] cpu_crit, mem_crit;
  assign cpu_crit = {1'b0, cpu_thr} + {1'b0, CpuMargin};
  assign mem_crit = {1'b0, mem_thr} + {1'b0, MemMargin};

  logic fire_cpu, fire_int, fire_ext;
  assign fire_cpu = (bt_r >= cpu_thr) && cool_ok(now_r, last_cpu_r, cooldown_r);
  assign fire_int = (int_total_r != '0) && (ui_r >= mem_thr)
                    && cool_ok(now_r, last_int_r, cooldown_r);
  assign fire_ext = (ext_total_r != '0) && (ue_r >= mem_thr)
                    && cool_ok(now_r, last_ext_r, cooldown_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_DIV_A;
      S_DIV_A:  state_nxt = S_WAIT_A;
      S_WAIT_A: if (div_ctl.done) state_nxt = S_DIV_B;
      S_DIV_B:  state_nxt = S_WAIT_B;
      S_WAIT_B: if (div_ctl.done) state_nxt = S_DIV_I;
      S_DIV_I:  state_nxt = S_WAIT_I;
      S_WAIT_I: if (div_ctl.done) state_nxt = S_DIV_E;
      S_DIV_E:  state_nxt = S_WAIT_E;
      S_WAIT_E: if (div_ctl.done) state_nxt = S_ALERT;
      S_ALERT:  state_nxt = S_OUT;
      S_OUT:    if (out_acc) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      int_total_r <= '0;
      ext_total_r <= '0;
      cpu_pct_r <= 7'd90;
      mem_pct_r <= 7'd85;
      cooldown_r <= 40'd10000000;
      prev_time_r <= '0;
      prev_idle_a_r <= '0;
      prev_idle_b_r <= '0;
      min_int_r <= '1;
      min_ext_r <= '1;
      last_cpu_r <= '0;
      last_int_r <= '0;
      last_ext_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgIntTotal: int_total_r <= cfg_data[WordW-1:0];
          CfgExtTotal: ext_total_r <= cfg_data[WordW-1:0];
          CfgCpuPct:   cpu_pct_r <= cfg_data[ThrW-1:0];
          CfgMemPct:   mem_pct_r <= cfg_data[ThrW-1:0];
          CfgCooldown: cooldown_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_time_r <= in_sample_time;
        if (in_low_water_internal < min_int_r) min_int_r <= in_low_water_internal;
        if (in_low_water_external < min_ext_r) min_ext_r <= in_low_water_external;
      end
      if (state_r == S_ALERT) begin
        if (calc_r) begin
          prev_idle_a_r <= ia_r;
          prev_idle_b_r <= ib_r;
        end
        if (fire_cpu) last_cpu_r <= now_r;
        if (fire_int) last_int_r <= now_r;
        if (fire_ext) last_ext_r <= now_r;
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
    if (in_acc) begin
      now_r <= in_sample_time;
      dt_r <= in_sample_time - prev_time_r;
      calc_r <= (prev_time_r != '0) && (in_sample_time > prev_time_r);
      ia_r <= in_idle_a_present ? in_idle_count_a : '0;
      ib_r <= in_idle_b_present ? in_idle_count_b : '0;
      fi_r <= in_free_internal;
      fe_r <= in_free_external;
    end
    if (state_r == S_WAIT_A && div_ctl.done)
      ba_r <= (calc_r && ia_r >= prev_idle_a_r) ? busy_q : '0;
    if (state_r == S_WAIT_B && div_ctl.done) begin
      bb_r <= (calc_r && ib_r >= prev_idle_b_r) ? busy_q : '0;
    end
    if (state_r == S_DIV_I)
      bt_r <= PctW'(({1'b0, ba_r} + {1'b0, bb_r}) >> 1);
    if (state_r == S_WAIT_I && div_ctl.done)
      ui_r <= (int_total_r == '0 || fi_r >= int_total_r) ? '0 : PctW'(div_q);
    if (state_r == S_WAIT_E && div_ctl.done)
      ue_r <= (ext_total_r == '0 || fe_r >= ext_total_r) ? '0 : PctW'(div_q);
    if (state_r == S_ALERT) begin
      a_cpu_r <= fire_cpu ? (({1'b0, bt_r} >= cpu_crit) ? AlertCrit : AlertWarn)
                          : AlertNone;
      a_int_r <= fire_int ? (({1'b0, ui_r} >= mem_crit) ? AlertCrit : AlertWarn)
                          : AlertNone;
      a_ext_r <= fire_ext ? (({1'b0, ue_r} >= mem_crit) ? AlertCrit : AlertWarn)
                          : AlertNone;
    end
  end

  assign out_busy_a = ba_r;
  assign out_busy_b = bb_r;
  assign out_busy_total = bt_r;
  assign out_history_min_internal = min_int_r;
  assign out_history_min_external = min_ext_r;
  assign out_used_internal = ui_r;
  assign out_used_external = ue_r;
  assign out_cpu_alert = a_cpu_r;
  assign out_internal_alert = a_int_r;
  assign out_external_alert = a_ext_r;

  `CHK_IMPL(a_one_item, clk, rst_n, in_acc, state_r == S_IDLE && !out_valid)
  `CHK_NEXT(a_valid_after_alert, clk, rst_n, state_r == S_ALERT, out_valid)
  `CHK_IMPL(a_div_idle_on_start, clk, rst_n, div_start, !div_ctl.busy)
  `CHK_IMPL(a_out_in_out_state, clk, rst_n, out_valid, state_r == S_OUT)
endmodule

/* design/lma_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module lma_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lma_pkg::DivNW-1:0]  num,
  input  logic [lma_pkg::DivDW-1:0]  den,
  output lma_pkg::div_ctl_t          ctl,
  output logic [lma_pkg::DivNW-1:0]  quot
);
  import lma_pkg::*;
  localparam int CntW = $clog2(DivNW + 1);

  logic [DivNW-1:0] q_r, q_nxt;
  logic [DivDW:0]   rem_r, rem_nxt;
  logic [DivDW-1:0] den_r, den_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DivDW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DivDW-1:0], q_r[DivNW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CntW'(DivNW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[DivNW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DivNW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
  assign quot = q_r;
endmodule
